// ===== hw/rtl/skt_pkg.sv =====
package skt_pkg;

   localparam int KEY_BITS          = 32;
   localparam int DEPTH_DEFAULT     = 64;
   localparam int PAYLOAD_BITS_DFLT = 32;

   // request codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_UPDATE = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic signed [KEY_BITS-1:0] key;
      logic [31:0]                payload;
   } skt_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  index;
      logic [31:0] found_payload;
      logic [6:0]  count;
   } skt_rsp_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic       capture;
      logic       apply;
      logic [1:0] op;
      logic       found;
      logic       room;
   } skt_ctl_type;

endpackage

// ===== hw/rtl/skt_cell.sv =====
module skt_cell
   import skt_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int PW    = 32,
   parameter int CNT_W = 7
) (
   input  logic                clock,
   input  skt_ctl_type         ctl,
   input  logic [KEY_BITS-1:0] cmp_key,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [PW-1:0]       new_pl,
   input  logic [CNT_W-1:0]    count,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [PW-1:0]       left_pl,
   input  logic                left_gt,
   input  logic                left_eq,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [PW-1:0]       right_pl,
   output logic [KEY_BITS-1:0] key_out,
   output logic [PW-1:0]       pl_out,
   output logic                gt_out,
   output logic                eq_out,
   output logic                ins_hot,
   output logic                match_hot
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [PW-1:0]       pl_ff, pl_in;
   logic                gt_ff, gt_in;
   logic                eq_ff, eq_in;
   logic                valid;

   // empty slots count as greater so the insert point is always found
   assign valid = (CNT_W'(IDX) < count);

   always_comb begin
      gt_in = gt_ff;
      eq_in = eq_ff;
      if (ctl.capture) begin
         gt_in = !valid || ($signed(key_ff) > $signed(cmp_key));
         eq_in = valid && (key_ff == cmp_key);
      end
   end

   assign ins_hot   = gt_ff && !left_gt;
   assign match_hot = eq_ff && !left_eq;

   always_comb begin
      key_in = key_ff;
      pl_in  = pl_ff;
      if (ctl.apply) begin
         case (ctl.op)
            OP_INSERT: begin
               if (ctl.room) begin
                  if (left_gt) begin
                     key_in = left_key;
                     pl_in  = left_pl;
                  end else if (gt_ff) begin
                     key_in = new_key;
                     pl_in  = new_pl;
                  end
               end
            end
            OP_DELETE: begin
               // everything from the match upward has key >= the request key
               if (ctl.found && (gt_ff || eq_ff)) begin
                  key_in = right_key;
                  pl_in  = right_pl;
               end
            end
            OP_UPDATE: begin
               if (match_hot) begin
                  pl_in = new_pl;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pl_ff  <= pl_in;
      gt_ff  <= gt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign pl_out  = pl_ff;
   assign gt_out  = gt_ff;
   assign eq_out  = eq_ff;

endmodule

// ===== hw/rtl/sorted_key_table_unit.sv =====
// sorted key table: up to DEPTH entries of signed key plus payload, kept in
// ascending key order in a row of cells, with an entry count beside them
// request channel: start with req_data (req_type, key, payload); a word is
// taken at a clock edge where start is high and busy is low
// result channel: rsp_data (status, index, found_payload, count) shows for
// exactly one cycle with rsp_strobe high; the receiver cannot stall it
// timing: the edge that takes the word also loads each cell's compare
// flags (greater, equal) against the request key; busy is high for the
// next cycle, and at the edge that ends it the cells from the insert point
// or match upward shift by one place (insert or delete) or one cell is
// written (update), and the result word is registered
// rsp_strobe is high in the cycle after that edge, and busy is already low
// then, so a new word can be taken while the result shows, but never while
// busy; the cost of a request does not depend on how full the table is
// reset: busy, rsp_strobe and the entry count clear; cell contents stay
// undefined and are only read below the count
module sorted_key_table_unit
   import skt_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DFLT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  skt_req_type req_data,
   output logic        rsp_strobe,
   output skt_rsp_type rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IW    = (IDX_W > 6) ? IDX_W : 6;
   // payload bits above the input word's width can never be set
   localparam int PW    = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

   // control state
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             strobe_ff, strobe_in;

   // request held for the apply cycle
   logic [1:0]          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [PW-1:0]       pl_ff;

   skt_rsp_type rsp_ff, rsp_in;

   logic        capture;
   skt_ctl_type ctl;

   // cell row
   logic [KEY_BITS-1:0] cell_key [DEPTH];
   logic [PW-1:0]       cell_pl  [DEPTH];
   logic [DEPTH-1:0]    cell_gt, cell_eq, ins_hot, match_hot;

   logic            room, found;
   logic [IW-1:0]   ins_idx, match_idx;
   logic [PW-1:0]   match_pl;

   assign capture = start && !busy_ff;
   assign room    = (count_ff < CNT_W'(DEPTH));
   assign found   = |match_hot;

   assign ctl.capture = capture;
   assign ctl.apply   = busy_ff;
   assign ctl.op      = op_ff;
   assign ctl.found   = found;
   assign ctl.room    = room;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [KEY_BITS-1:0] l_key, r_key;
         logic [PW-1:0]       l_pl, r_pl;
         logic                l_gt, l_eq;

         if (g == 0) begin : g_first
            assign l_key = '0;
            assign l_pl  = '0;
            assign l_gt  = 1'b0;
            assign l_eq  = 1'b0;
         end else begin : g_mid
            assign l_key = cell_key[g-1];
            assign l_pl  = cell_pl[g-1];
            assign l_gt  = cell_gt[g-1];
            assign l_eq  = cell_eq[g-1];
         end

         // the last cell shifts in its own contents, i.e. holds
         if (g == DEPTH - 1) begin : g_last
            assign r_key = cell_key[g];
            assign r_pl  = cell_pl[g];
         end else begin : g_inner
            assign r_key = cell_key[g+1];
            assign r_pl  = cell_pl[g+1];
         end

         skt_cell #(
            .IDX   (g),
            .PW    (PW),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .cmp_key   (req_data.key),
            .new_key   (key_ff),
            .new_pl    (pl_ff),
            .count     (count_ff),
            .left_key  (l_key),
            .left_pl   (l_pl),
            .left_gt   (l_gt),
            .left_eq   (l_eq),
            .right_key (r_key),
            .right_pl  (r_pl),
            .key_out   (cell_key[g]),
            .pl_out    (cell_pl[g]),
            .gt_out    (cell_gt[g]),
            .eq_out    (cell_eq[g]),
            .ins_hot   (ins_hot[g]),
            .match_hot (match_hot[g])
         );
      end
   endgenerate

   // both hot vectors are one-hot or empty, so plain or-trees encode them
   always_comb begin
      ins_idx   = '0;
      match_idx = '0;
      match_pl  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (ins_hot[i]) begin
            ins_idx = ins_idx | IW'(i);
         end
         if (match_hot[i]) begin
            match_idx = match_idx | IW'(i);
         end
         match_pl = match_pl | (cell_pl[i] & {PW{match_hot[i]}});
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      if (capture) begin
         busy_in = 1'b1;
      end else if (busy_ff) begin
         busy_in   = 1'b0;
         strobe_in = 1'b1;
         rsp_in.status        = ST_DONE;
         rsp_in.index         = '0;
         rsp_in.found_payload = '0;
         case (op_ff)
            OP_INSERT: begin
               if (room) begin
                  count_in     = count_ff + CNT_W'(1);
                  rsp_in.index = ins_idx[5:0];
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end
            OP_DELETE: begin
               if (found) begin
                  count_in     = count_ff - CNT_W'(1);
                  rsp_in.index = match_idx[5:0];
               end else begin
                  rsp_in.status = ST_MISS;
               end
            end
            OP_LOOKUP: begin
               if (found) begin
                  rsp_in.index         = match_idx[5:0];
                  rsp_in.found_payload = 32'(match_pl);
               end else begin
                  rsp_in.status = ST_MISS;
               end
            end
            default: begin
               if (found) begin
                  rsp_in.index = match_idx[5:0];
               end else begin
                  rsp_in.status = ST_MISS;
               end
            end
         endcase
         rsp_in.count = 7'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (capture) begin
         op_ff  <= req_data.req_type;
         key_ff <= req_data.key;
         pl_ff  <= req_data.payload[PW-1:0];
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hw/rtl/skt_checker.sv =====
module skt_checker
   import skt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input skt_rsp_type rsp_data
);

   // a taken word sets busy, then rsp_strobe as busy drops
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result word missing two cycles after request");

   // a taken word keeps the block busy for its apply cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("busy not raised after request");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && !$past(rsp_strobe)))
      else $error("result strobe overlaps busy or repeats");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status == ST_DONE || rsp_data.status == ST_FULL ||
                      rsp_data.status == ST_MISS))
      else $error("undefined status code");

   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_FULL) |-> (rsp_data.count == 7'(DEPTH)))
      else $error("full reported below capacity");

endmodule

bind sorted_key_table_unit skt_checker #(.DEPTH(DEPTH)) u_skt_checker (.*);

// ===== sim/tb_top.sv =====
module tb_top;
   import skt_pkg::*;

   localparam int DEPTH     = DEPTH_DEFAULT;
   localparam int MAX_SHOWN = 50;  // cap on mismatch reports

   logic        clock;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   logic        busy;
   skt_req_type req_data = '0;
   logic        rsp_strobe;
   skt_rsp_type rsp_data;

   // travels with each request word: a result typed into the directed table
   logic        word_fixed     = 1'b0;
   skt_rsp_type word_fixed_rsp = '0;

   sorted_key_table_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // table predictor: sorted copy of the keys and payloads plus the count
   // ---------------------------------------------------------------------
   logic signed [31:0] stored_keys [DEPTH];
   logic [31:0]        stored_payloads [DEPTH];
   int                 stored_count = 0;

   // results still owed by the block, oldest first
   skt_rsp_type pending_results[$];
   skt_rsp_type predicted;
   skt_rsp_type oldest;
   int          err_count = 0;

   // what the run reached
   int n_words = 0;
   int n_inserted = 0;
   int n_refused = 0;
   int n_missed = 0;
   int n_removed = 0;
   int n_hits = 0;
   int peak_count = 0;

   function automatic skt_rsp_type apply_request(input skt_req_type w);
      skt_rsp_type r;
      int          pos;
      r   = '0;
      pos = stored_count;
      if (w.req_type == OP_INSERT) begin
         if (stored_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // new entry goes before the first strictly greater key
            for (int i = 0; i < stored_count; i++) begin
               if ($signed(w.key) < $signed(stored_keys[i])) begin
                  pos = i;
                  break;
               end
            end
            for (int i = stored_count; i > pos; i--) begin
               stored_keys[i]     = stored_keys[i-1];
               stored_payloads[i] = stored_payloads[i-1];
            end
            stored_keys[pos]     = w.key;
            stored_payloads[pos] = w.payload;
            stored_count++;
            r.index = 6'(pos);
         end
      end else begin
         // first (lowest) matching entry
         for (int i = 0; i < stored_count; i++) begin
            if (stored_keys[i] == w.key) begin
               pos = i;
               break;
            end
         end
         if (pos >= stored_count) begin
            r.status = ST_MISS;
         end else begin
            r.index = 6'(pos);
            case (w.req_type)
               OP_DELETE: begin
                  for (int i = pos; i + 1 < stored_count; i++) begin
                     stored_keys[i]     = stored_keys[i+1];
                     stored_payloads[i] = stored_payloads[i+1];
                  end
                  stored_count--;
               end
               OP_LOOKUP: begin
                  r.found_payload = stored_payloads[pos];
               end
               default: begin
                  stored_payloads[pos] = w.payload;
               end
            endcase
         end
      end
      r.count = 7'(stored_count);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         err_count++;
         if (err_count <= MAX_SHOWN)
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------
   // monitor: results are taken first, then the newly accepted word, so a
   // result and a word on the same edge line up with the right expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            err_count++;
            if (err_count <= MAX_SHOWN)
               $error("result word with no request pending");
         end else begin
            oldest = pending_results.pop_front();
            check_field("status", 32'(oldest.status), 32'(rsp_data.status));
            check_field("index", 32'(oldest.index), 32'(rsp_data.index));
            check_field("found_payload", oldest.found_payload, rsp_data.found_payload);
            check_field("count", 32'(oldest.count), 32'(rsp_data.count));
         end
      end
      if (!reset && start && !busy) begin
         predicted = apply_request(req_data);
         pending_results.push_back(word_fixed ? word_fixed_rsp : predicted);
         n_words++;
         if (predicted.status == ST_FULL) n_refused++;
         if (predicted.status == ST_MISS) n_missed++;
         if (predicted.status == ST_DONE) begin
            if (req_data.req_type == OP_INSERT) n_inserted++;
            if (req_data.req_type == OP_DELETE) n_removed++;
            if (req_data.req_type == OP_LOOKUP) n_hits++;
         end
         if (int'(predicted.count) > peak_count) peak_count = int'(predicted.count);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   typedef struct {
      skt_req_type word;
      bit          fixed;
      skt_rsp_type rsp;
   } dir_row_type;

   dir_row_type dir_rows[$];
   int          burst_left = 0;

   task automatic add_row(input logic [1:0] op, input logic [31:0] key,
                          input logic [31:0] pay, input bit fixed,
                          input logic [1:0] st, input int idx,
                          input logic [31:0] fpl, input int cnt);
      dir_row_type row;
      row.word  = '{req_type: op, key: key, payload: pay};
      row.fixed = fixed;
      row.rsp   = '{status: st, index: idx[5:0], found_payload: fpl, count: cnt[6:0]};
      dir_rows.push_back(row);
   endtask

   // burst-and-gap pacing on the request side, then one word handed over
   task automatic send_word(input skt_req_type w, input bit fixed,
                            input skt_rsp_type fixed_rsp);
      int gap;
      if (burst_left == 0) begin
         // one burst in four runs long and without a gap
         if ($urandom_range(3) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(60, 30);
         end else begin
            gap        = $urandom_range(6);
            burst_left = $urandom_range(12, 1);
         end
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start          <= 1'b1;
      req_data       <= w;
      word_fixed     <= fixed;
      word_fixed_rsp <= fixed_rsp;
      // hold until the block takes the word
      do @(posedge clock); while (busy);
   endtask

   // weights in percent for insert, delete and lookup; update takes the rest
   function automatic skt_req_type random_word(input int w_ins, input int w_del,
                                                input int w_look);
      skt_req_type w;
      int          pick;
      pick = $urandom_range(99);
      if (pick < w_ins)                       w.req_type = OP_INSERT;
      else if (pick < w_ins + w_del)          w.req_type = OP_DELETE;
      else if (pick < w_ins + w_del + w_look) w.req_type = OP_LOOKUP;
      else                                    w.req_type = OP_UPDATE;
      // small key pool gives hits and duplicates, the rest spans all bits
      pick = $urandom_range(9);
      if (pick < 7) begin
         w.key = $urandom_range(15) - 8;
      end else if (pick == 7) begin
         case ($urandom_range(3))
            0:       w.key = 32'h8000_0000;
            1:       w.key = 32'h7fff_ffff;
            2:       w.key = 32'hffff_ffff;
            default: w.key = 32'h0;
         endcase
      end else begin
         w.key = $urandom;
      end
      pick = $urandom_range(9);
      if (pick == 0)      w.payload = 32'h0;
      else if (pick == 1) w.payload = 32'hffff_ffff;
      else                w.payload = $urandom;
      return w;
   endfunction

   initial begin
      // phase plan: fill past full, drain, mix, fill again
      int phase_len [4];
      int phase_ins [4];
      int phase_del [4];
      int phase_look[4];
      phase_len  = '{100, 110, 140, 100};
      phase_ins  = '{80, 5, 25, 80};
      phase_del  = '{5, 75, 25, 5};
      phase_look = '{10, 10, 25, 10};

      // empty table: every keyed request misses
      add_row(OP_LOOKUP, 32'h0,         32'h0,         1, ST_MISS, 0, 32'h0, 0);
      add_row(OP_DELETE, 32'h5,         32'h0,         1, ST_MISS, 0, 32'h0, 0);
      add_row(OP_UPDATE, 32'h5,         32'hdead_beef, 1, ST_MISS, 0, 32'h0, 0);
      // key and payload extremes, then ordering around them
      add_row(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 1, ST_DONE, 0, 32'h0, 1);
      add_row(OP_INSERT, 32'h8000_0000, 32'h0,         1, ST_DONE, 0, 32'h0, 2);
      add_row(OP_INSERT, 32'h0,         32'ha5a5_a5a5, 1, ST_DONE, 1, 32'h0, 3);
      // an equal key lands after the one already held
      add_row(OP_INSERT, 32'h0,         32'h5a5a_5a5a, 1, ST_DONE, 2, 32'h0, 4);
      add_row(OP_INSERT, 32'hffff_ffff, 32'h1,         1, ST_DONE, 1, 32'h0, 5);
      // lookup and update act on the first of the duplicates
      add_row(OP_LOOKUP, 32'h0,         32'h0,         1, ST_DONE, 2, 32'ha5a5_a5a5, 5);
      add_row(OP_UPDATE, 32'h0,         32'h1234_5678, 1, ST_DONE, 2, 32'h0, 5);
      add_row(OP_LOOKUP, 32'h0,         32'h0,         1, ST_DONE, 2, 32'h1234_5678, 5);
      add_row(OP_LOOKUP, 32'h7fff_ffff, 32'h0,         1, ST_DONE, 4, 32'hffff_ffff, 5);
      add_row(OP_LOOKUP, 32'h1,         32'h0,         1, ST_MISS, 0, 32'h0, 5);
      // delete closes the gap, the second duplicate moves up
      add_row(OP_DELETE, 32'h0,         32'h0,         1, ST_DONE, 2, 32'h0, 4);
      add_row(OP_LOOKUP, 32'h0,         32'h0,         1, ST_DONE, 2, 32'h5a5a_5a5a, 4);
      add_row(OP_DELETE, 32'h8000_0000, 32'h0,         1, ST_DONE, 0, 32'h0, 3);
      add_row(OP_DELETE, 32'h7fff_ffff, 32'h0,         1, ST_DONE, 2, 32'h0, 2);
      add_row(OP_DELETE, 32'h7fff_ffff, 32'h0,         1, ST_MISS, 0, 32'h0, 2);
      // left to the predictor
      add_row(OP_INSERT, 32'h100,       32'h0f0f_0f0f, 0, ST_DONE, 0, 32'h0, 0);
      add_row(OP_LOOKUP, 32'h100,       32'h0,         0, ST_DONE, 0, 32'h0, 0);
      add_row(OP_UPDATE, 32'hffff_ffff, 32'hf0f0_f0f0, 0, ST_DONE, 0, 32'h0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r])
         send_word(dir_rows[r].word, dir_rows[r].fixed, dir_rows[r].rsp);

      // table full refusals come up at the end of each fill phase
      for (int p = 0; p < 4; p++)
         for (int n = 0; n < phase_len[p]; n++)
            send_word(random_word(phase_ins[p], phase_del[p], phase_look[p]), 1'b0, '0);

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // then wait on to catch a stray result word
      repeat (8) @(posedge clock);

      $display("covered %0d request words: %0d inserts, %0d refused on a full table",
               n_words, n_inserted, n_refused);
      $display("%0d deletes, %0d lookup hits, %0d missed keys, peak count %0d",
               n_removed, n_hits, n_missed, peak_count);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
